@@ design/nnis_pkg.sv @@
// Package: types and constants shared by the image scaler files.
package nnis_pkg;

	localparam int MaxDim   = 1024;
	localparam int SrcDepth = 16384;
	localparam int DimW     = 11;
	localparam int PosW     = 10;

	localparam logic [2:0] RegMode      = 3'd0;
	localparam logic [2:0] RegSrcWidth  = 3'd1;
	localparam logic [2:0] RegSrcHeight = 3'd2;
	localparam logic [2:0] RegDstWidth  = 3'd3;
	localparam logic [2:0] RegDstHeight = 3'd4;

	localparam logic KindLoad = 1'b0;
	localparam logic KindRead = 1'b1;

	typedef struct packed {
		logic [7:0]      in_alpha;
		logic [7:0]      in_blue;
		logic [7:0]      in_green;
		logic [7:0]      in_red;
		logic [PosW-1:0] pos_y;
		logic [PosW-1:0] pos_x;
		logic            kind;
	} in_item_t;

	typedef struct packed {
		logic       status;
		logic [7:0] out_alpha;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} out_item_t;

endpackage

@@ design/nnis_divider.sv @@
// Pipelined restoring divider: quotient = num / den, one quotient bit a stage.
module nnis_divider #(
	parameter int NumW = 21,
	parameter int DenW = 11,
	parameter int TagW = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	input  logic [TagW-1:0] tag,
	output logic [NumW-1:0] quo,
	output logic [TagW-1:0] tag_out
);
	logic [DenW:0]   rem_q [NumW+1];
	logic [NumW-1:0] num_q [NumW+1];
	logic [DenW-1:0] den_q [NumW+1];
	logic [TagW-1:0] tag_q [NumW+1];

	always_comb begin
		rem_q[0] = '0;
		num_q[0] = num;
		den_q[0] = den;
		tag_q[0] = tag;
	end

	for (genvar i = 0; i < NumW; i++) begin : g_stage
		logic [DenW+1:0] trial;
		logic [DenW:0]   rem_n;
		always_comb begin
			trial = {rem_q[i], num_q[i][NumW-1]} - {2'b00, den_q[i]};
			rem_n = trial[DenW+1] ? {rem_q[i][DenW-1:0], num_q[i][NumW-1]} : trial[DenW:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= rem_n;
				num_q[i+1] <= {num_q[i][NumW-2:0], ~trial[DenW+1]};
				den_q[i+1] <= den_q[i];
				tag_q[i+1] <= tag_q[i];
			end
		end
	end

	assign quo     = num_q[NumW];
	assign tag_out = tag_q[NumW];
endmodule

@@ design/nearest_neighbor_image_scaler.sv @@
// Nearest-neighbor / repeat-tile image scaler over a source pixel memory.
// A read result passes through the divider stages, the coordinate stage, the address
// multiply, the memory read and the output register.
// Throughput: one item per cycle; the whole pipe advances unless the output
// register holds an untaken result while stall is high.
// Reset clears the pipe valids and sets mode 0 and all sizes to 1; pixel memory is not cleared.
module nearest_neighbor_image_scaler #(
	parameter int SRC_DEPTH = nnis_pkg::SrcDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  nnis_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output nnis_pkg::out_item_t   out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	import nnis_pkg::*;

	localparam int AW   = $clog2(SRC_DEPTH);
	localparam int NumW = PosW + DimW;
	localparam int TxW  = 1 + PosW + 3;
	localparam int TyW  = PosW + 32;

	logic            mode_q;
	logic [DimW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [DimW-1:0] sw, sh, dw, dh;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0; src_w_q <= 11'd1; src_h_q <= 11'd1;
			dst_w_q <= 11'd1; dst_h_q <= 11'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegMode:      mode_q  <= cfg_data[0];
				RegSrcWidth:  src_w_q <= cfg_data[DimW-1:0];
				RegSrcHeight: src_h_q <= cfg_data[DimW-1:0];
				RegDstWidth:  dst_w_q <= cfg_data[DimW-1:0];
				RegDstHeight: dst_h_q <= cfg_data[DimW-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [DimW-1:0] clamp(input logic [DimW-1:0] v);
		return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
	endfunction
	assign sw = clamp(src_w_q);
	assign sh = clamp(src_h_q);
	assign dw = clamp(dst_w_q);
	assign dh = clamp(dst_h_q);

	// global pipe enable; output register acts as the only hold point
	logic adv;
	logic v_out_q;
	assign adv      = !(v_out_q && out_stall);
	assign in_stall = !adv;

	logic acc;
	assign acc = in_valid && adv;

	// stage 0: choose numerators/divisors. Scale: x*sw / dw. Tile: x / sw, rem later.
	logic [NumW-1:0] nx, ny;
	logic [DimW-1:0] ddx, ddy;
	logic            oor, rd, ld, ld_ok;
	always_comb begin
		rd    = acc && in_data.kind == KindRead;
		ld    = acc && in_data.kind == KindLoad;
		oor   = ({1'b0, in_data.pos_x} >= dw) || ({1'b0, in_data.pos_y} >= dh);
		ld_ok = ({1'b0, in_data.pos_x} < sw) && ({1'b0, in_data.pos_y} < sh);
		if (mode_q) begin
			nx = NumW'(in_data.pos_x); ny = NumW'(in_data.pos_y);
			ddx = sw; ddy = sh;
		end else begin
			nx = NumW'(in_data.pos_x * sw); ny = NumW'(in_data.pos_y * sh);
			ddx = dw; ddy = dh;
		end
		// zero divisor when the source size (tile) or destination size (scale) is zero; quotient then unused
		if (ddx == '0) ddx = DimW'(1);
		if (ddy == '0) ddy = DimW'(1);
	end

	// loads travel the same pipe as reads so the memory sees requests in order
	logic [TxW-1:0]  tag_xin, tag_x;
	logic [TyW-1:0]  tag_yin, tag_y;
	logic [NumW-1:0] qx, qy;
	logic            zsrc;
	assign zsrc    = (sw == '0) || (sh == '0);
	assign tag_xin = {rd, in_data.pos_x, oor, zsrc, mode_q};
	assign tag_yin = {in_data.pos_y, in_data.in_alpha, in_data.in_blue, in_data.in_green,
		in_data.in_red};

	nnis_divider #(.NumW(NumW), .DenW(DimW), .TagW(TxW)) u_divx (
		.clk, .en(adv), .num(nx), .den(ddx), .tag(tag_xin), .quo(qx), .tag_out(tag_x));
	nnis_divider #(.NumW(NumW), .DenW(DimW), .TagW(TyW)) u_divy (
		.clk, .en(adv), .num(ny), .den(ddy), .tag(tag_yin), .quo(qy), .tag_out(tag_y));

	logic            t_rd, t_oor, t_zs, t_md;
	logic [PosW-1:0] t_px, t_py;
	logic [31:0]     t_pix;
	assign {t_rd, t_px, t_oor, t_zs, t_md} = tag_x;
	assign {t_py, t_pix} = tag_y;

	// load: coordinate as given; tile: remainder = x - q*sw ; scale: source coord = q
	logic [NumW-1:0] sx, sy;
	always_comb begin
		if (!t_rd) begin
			sx = NumW'(t_px); sy = NumW'(t_py);
		end else if (t_md) begin
			sx = NumW'(t_px) - NumW'(qx[DimW-1:0] * sw);
			sy = NumW'(t_py) - NumW'(qy[DimW-1:0] * sh);
		end else begin
			sx = qx; sy = qy;
		end
	end

	// one valid bit per divider stage, for reads and in-range loads
	logic [NumW-1:0] vpipe_q;
	logic v_div, l_div;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vpipe_q <= '0;
		else if (adv) vpipe_q <= {vpipe_q[NumW-2:0], rd || (ld && ld_ok)};
	end
	assign v_div = vpipe_q[NumW-1] && t_rd;
	assign l_div = vpipe_q[NumW-1] && !t_rd;

	logic            v_s1, lv_s1, oor_s1, bad_s1;
	logic [DimW-1:0] sx_s1, sy_s1;
	logic [31:0]     pix_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; lv_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_div; lv_s1 <= l_div;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s1 <= t_oor;
			bad_s1 <= t_zs;
			sx_s1  <= sx[DimW-1:0];
			sy_s1  <= sy[DimW-1:0];
			pix_s1 <= t_pix;
		end
	end

	logic [2*DimW-1:0] raddr;
	assign raddr = sy_s1 * sw + 22'(sx_s1);

	logic            v_s2, lv_s2, oor_s2, miss_s2;
	logic [AW-1:0]   ra_s2;
	logic [31:0]     pix_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; lv_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1; lv_s2 <= lv_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s2  <= oor_s1;
			miss_s2 <= bad_s1 || (raddr >= (2*DimW)'(SRC_DEPTH));
			ra_s2   <= AW'(raddr);
			pix_s2  <= pix_s1;
		end
	end

	// pixel memory: one write, one registered read
	logic [31:0] mem [SRC_DEPTH];
	logic [31:0] rdata_s3;
	always_ff @(posedge clk) begin
		if (adv && lv_s2 && !miss_s2) mem[ra_s2] <= pix_s2;
		if (adv) rdata_s3 <= mem[ra_s2];
	end

	logic v_s3, oor_s3, miss_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s3 <= oor_s2; miss_s3 <= miss_s2;
		end
	end

	out_item_t res;
	always_comb begin
		res = '0;
		if (oor_s3) res.status = 1'b1;
		else if (!miss_s3) {res.out_alpha, res.out_blue, res.out_green, res.out_red} = rdata_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (adv) v_out_q <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) out_data <= res;
	end
	assign out_valid = v_out_q;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.out_red == 8'd0 && out_data.out_alpha == 8'd0)
		else $error("out of range result carries color");
`endif
endmodule

@@ sim/tb_nearest_neighbor_image_scaler.sv @@
// Self-checking testbench for the nearest-neighbor / repeat-tile image scaler.
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler;
	import nnis_pkg::*;

	localparam int Latency     = PosW + DimW + 3;
	localparam int InW         = $bits(in_item_t);
	localparam int QuietLo     = 600;
	localparam int QuietHi     = 1100;
	localparam logic [2:0] RegUnmapped = 3'd6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	nearest_neighbor_image_scaler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// scaler state as seen by the predictor
	logic [31:0] pixel_mem [SrcDepth];
	bit          pixel_set [SrcDepth];
	logic        cur_mode;
	logic [10:0] cur_sw, cur_sh, cur_dw, cur_dh;

	out_item_t   pixel_queue[$];
	int          n_fail = 0;
	int          n_loads = 0, n_reads = 0, n_oob = 0, n_results = 0;
	int unsigned cyc = 0;
	bit          hold_done = 0;
	int          hold_cnt = 0;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic int clamp_dim(logic [10:0] v);
		return (int'(v) > MaxDim) ? MaxDim : int'(v);
	endfunction

	// Source entry a read maps to; -1 when the read result takes no data from the pixel memory.
	function automatic int read_entry(int px, int py, output int sx, output int sy);
		int sw, sh, dw, dh, a;
		sw = clamp_dim(cur_sw); sh = clamp_dim(cur_sh);
		dw = clamp_dim(cur_dw); dh = clamp_dim(cur_dh);
		sx = 0; sy = 0;
		if (px >= dw || py >= dh || sw == 0 || sh == 0) return -1;
		if (cur_mode == 1'b0) begin
			sx = (px * sw) / dw;
			sy = (py * sh) / dh;
		end else begin
			sx = px % sw;
			sy = py % sh;
		end
		a = sy * sw + sx;
		return (a < SrcDepth) ? a : -1;
	endfunction

	// Apply one accepted request; returns 1 with the pixel when a read.
	function automatic bit scale_pixel(in_item_t it, output out_item_t r);
		int sw, sh, a, sx, sy;
		r = '0;
		sw = clamp_dim(cur_sw); sh = clamp_dim(cur_sh);
		if (it.kind == KindLoad) begin
			if (int'(it.pos_x) < sw && int'(it.pos_y) < sh) begin
				a = int'(it.pos_y) * sw + int'(it.pos_x);
				if (a < SrcDepth) begin
					pixel_mem[a] = {it.in_alpha, it.in_blue, it.in_green, it.in_red};
					pixel_set[a] = 1'b1;
				end
			end
			return 1'b0;
		end
		if (int'(it.pos_x) >= clamp_dim(cur_dw) || int'(it.pos_y) >= clamp_dim(cur_dh)) begin
			r.status = 1'b1;
			return 1'b1;
		end
		a = read_entry(int'(it.pos_x), int'(it.pos_y), sx, sy);
		if (a >= 0)
			{r.out_alpha, r.out_blue, r.out_green, r.out_red} = pixel_mem[a];
		return 1'b1;
	endfunction

	task automatic send_request(in_item_t it, bit has_typed, out_item_t typed);
		out_item_t r;
		while (cyc >= QuietHi || cyc < QuietLo ? ($urandom_range(99) < 10) : 1'b0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		if (scale_pixel(it, r)) begin
			pixel_queue.push_back(has_typed ? typed : r);
			n_reads++;
			if (r.status) n_oob++;
		end else begin
			n_loads++;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			RegMode:      cur_mode = val[0];
			RegSrcWidth:  cur_sw = val[10:0];
			RegSrcHeight: cur_sh = val[10:0];
			RegDstWidth:  cur_dw = val[10:0];
			RegDstHeight: cur_dh = val[10:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
	endtask

	// upper data bits are junk; the block keeps only the field width
	task automatic set_geometry(logic m, int sw, int sh, int dw, int dh);
		write_reg(RegMode, {31'($urandom()), m});
		write_reg(RegSrcWidth, {21'($urandom()), 11'(sw)});
		write_reg(RegSrcHeight, {21'($urandom()), 11'(sh)});
		write_reg(RegDstWidth, {21'($urandom()), 11'(dw)});
		write_reg(RegDstHeight, {21'($urandom()), 11'(dh)});
	endtask

	function automatic in_item_t rand_load(int sw, int sh);
		in_item_t it;
		it = in_item_t'(InW'({$urandom(), $urandom()}));
		it.kind = KindLoad;
		if ($urandom_range(99) < 85 && sw > 0 && sh > 0) begin
			it.pos_x = PosW'($urandom_range(sw - 1));
			it.pos_y = PosW'($urandom_range(sh - 1));
		end
		return it;
	endfunction

	// receiver: random stalls, one long hold-off, quiet window
	always @(posedge clk) begin
		if (!hold_done && n_results == 20) begin
			hold_done <= 1'b1;
			hold_cnt  <= 300;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (cyc >= QuietLo && cyc < QuietHi) ? 1'b0 : ($urandom_range(99) < 10);
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results <= n_results + 1;
			if (pixel_queue.size() == 0) begin
				$error("unexpected result %h", out_data);
				n_fail++;
			end else begin
				e = pixel_queue.pop_front();
				if (out_data.out_red !== e.out_red) begin
					$error("out_red exp %h got %h", e.out_red, out_data.out_red); n_fail++;
				end
				if (out_data.out_green !== e.out_green) begin
					$error("out_green exp %h got %h", e.out_green, out_data.out_green); n_fail++;
				end
				if (out_data.out_blue !== e.out_blue) begin
					$error("out_blue exp %h got %h", e.out_blue, out_data.out_blue); n_fail++;
				end
				if (out_data.out_alpha !== e.out_alpha) begin
					$error("out_alpha exp %h got %h", e.out_alpha, out_data.out_alpha); n_fail++;
				end
				if (out_data.status !== e.status) begin
					$error("status exp %h got %h", e.status, out_data.status); n_fail++;
				end
			end
		end
	end

	typedef struct {
		logic        kind;
		int          x, y;
		logic [31:0] rgba;
		bit          typed;
		out_item_t   res;
	} dir_row_t;

	localparam out_item_t PixOnes = '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
	localparam out_item_t PixZero = '0;
	localparam out_item_t PixOob  = '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00};

	// geometry per phase: mode, src w/h, dst w/h
	int phase_cfg [9][5] = '{
		'{0, 4, 3, 9, 7}, '{1, 5, 2, 16, 16}, '{0, 1024, 1024, 1024, 1024},
		'{1, 2047, 16, 1, 1}, '{0, 0, 8, 8, 8}, '{1, 8, 8, 0, 5},
		'{0, 16, 16, 3, 2}, '{1, 1, 1, 1024, 1024}, '{0, 2047, 2047, 2047, 2047}
	};

	initial begin
		dir_row_t  rows [10];
		in_item_t  it;
		out_item_t none;
		int        sw, sh, dw, dh, a, sx, sy, k;

		cur_mode = 0; cur_sw = 1; cur_sh = 1; cur_dw = 1; cur_dh = 1;
		none = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{KindLoad, 0, 0, 32'hFFFF_FFFF, 0, PixZero},
			'{KindRead, 0, 0, 32'h0, 1, PixOnes},
			'{KindLoad, 0, 0, 32'h0, 0, PixZero},
			'{KindRead, 0, 0, 32'hFFFF_FFFF, 1, PixZero},
			'{KindLoad, 1023, 1023, 32'hA5A5_5A5A, 0, PixZero},  // ignored
			'{KindLoad, 1, 0, 32'h1234_5678, 0, PixZero},        // ignored
			'{KindRead, 0, 0, 32'h0, 1, PixZero},
			'{KindRead, 1023, 0, 32'h0, 1, PixOob},
			'{KindRead, 0, 1023, 32'h0, 1, PixOob},
			'{KindRead, 1023, 1023, 32'h0, 1, PixOob}
		};
		foreach (rows[i]) begin
			it = '0;
			it.kind  = rows[i].kind;
			it.pos_x = PosW'(rows[i].x);
			it.pos_y = PosW'(rows[i].y);
			{it.in_alpha, it.in_blue, it.in_green, it.in_red} = rows[i].rgba;
			send_request(it, rows[i].typed, rows[i].res);
		end
		drain();
		write_reg(RegUnmapped, 32'hFFFF_FFFF);  // unmapped index, no effect

		foreach (phase_cfg[p]) begin
			set_geometry(1'(phase_cfg[p][0]), phase_cfg[p][1], phase_cfg[p][2],
				phase_cfg[p][3], phase_cfg[p][4]);
			sw = clamp_dim(cur_sw); sh = clamp_dim(cur_sh);
			dw = clamp_dim(cur_dw); dh = clamp_dim(cur_dh);
			// fill small sources completely first
			if (sw * sh <= 64)
				for (int y = 0; y < sh; y++)
					for (int x = 0; x < sw; x++) begin
						it = rand_load(sw, sh);
						it.pos_x = PosW'(x); it.pos_y = PosW'(y);
						send_request(it, 0, none);
					end
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(99) < 25) begin
					it = rand_load(sw, sh);
				end else begin
					it = in_item_t'(InW'({$urandom(), $urandom()}));
					it.kind = KindRead;
					if ($urandom_range(99) < 85 && dw > 0 && dh > 0) begin
						k = $urandom_range(3);
						it.pos_x = PosW'((k == 0) ? dw - 1 : int'($urandom_range(dw - 1)));
						it.pos_y = PosW'((k == 1) ? dh - 1 : int'($urandom_range(dh - 1)));
					end
					a = read_entry(int'(it.pos_x), int'(it.pos_y), sx, sy);
					// never read an entry that was not loaded; load it instead
					if (a >= 0 && !pixel_set[a]) begin
						it = rand_load(sw, sh);
						it.pos_x = PosW'(sx); it.pos_y = PosW'(sy);
					end
				end
				send_request(it, 0, none);
			end
			drain();
		end

		$display("Covered %0d loads and %0d reads (%0d out of range) over %0d geometries.",
			n_loads, n_reads, n_oob, $size(phase_cfg));
		$display("Long output hold-off applied: %0d", hold_done);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
design/nnis_pkg.sv
design/nnis_divider.sv
design/nearest_neighbor_image_scaler.sv
sim/tb_nearest_neighbor_image_scaler.sv
